### src/axss_pkg.sv
// ============================================================================
// axss_pkg
// Shared types, register codes and constants of the axis slew smoother.
// ============================================================================
`default_nettype none

package axss_pkg;

  // Fixed point: 1.0 = 16384.
  localparam logic signed [16:0] RAW_POS_MAX = 17'sd16384;
  localparam logic signed [16:0] RAW_NEG_MAX = -17'sd16384;
  localparam logic [14:0]        STEP_MAX    = 15'd32767;

  // Register reset values.
  localparam logic [14:0] DEADZONE_RST = 15'd0;
  localparam logic        SNAP_RST     = 1'b0;
  localparam logic [15:0] RISE_RST     = 16'd768;
  localparam logic [15:0] FALL_RST     = 16'd768;

  // Register indexes (byte address = 4 * index).
  typedef enum logic [1:0] {
    REG_DEADZONE = 2'd0,
    REG_SNAP     = 2'd1,
    REG_RISE     = 2'd2,
    REG_FALL     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [14:0] deadzone_level;
    logic        snap_enable;
    logic [15:0] rise_rate;
    logic [15:0] fall_rate;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;  // capture frame, form target
    logic mul1;     // rate * frame time, snap check
    logic mul2;     // first product * |target|
    logic commit;   // update held value, load result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tgt_zero;
  } stat_t;

endpackage

`default_nettype wire

### src/axss_regs.sv
// ============================================================================
// axss_regs
// Configuration register file behind the APB-style write/read port.
// ============================================================================
`default_nettype none

module axss_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output axss_pkg::cfg_t     cfg
);

  axss_pkg::cfg_t     cfg_r, cfg_nxt;
  axss_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx   = axss_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        axss_pkg::REG_DEADZONE: cfg_nxt.deadzone_level = pwdata[14:0];
        axss_pkg::REG_SNAP:     cfg_nxt.snap_enable    = pwdata[0];
        axss_pkg::REG_RISE:     cfg_nxt.rise_rate      = pwdata[15:0];
        axss_pkg::REG_FALL:     cfg_nxt.fall_rate      = pwdata[15:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadzone_level <= axss_pkg::DEADZONE_RST;
      cfg_r.snap_enable    <= axss_pkg::SNAP_RST;
      cfg_r.rise_rate      <= axss_pkg::RISE_RST;
      cfg_r.fall_rate      <= axss_pkg::FALL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      axss_pkg::REG_DEADZONE: prdata = {17'd0, cfg_r.deadzone_level};
      axss_pkg::REG_SNAP:     prdata = {31'd0, cfg_r.snap_enable};
      axss_pkg::REG_RISE:     prdata = {16'd0, cfg_r.rise_rate};
      axss_pkg::REG_FALL:     prdata = {16'd0, cfg_r.fall_rate};
      default:                prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### src/axss_ctrl.sv
// ============================================================================
// axss_ctrl
// Sequencer for one frame: capture, one or two multiplier passes, update,
// and the result valid flag.
// ============================================================================
`default_nettype none

module axss_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  input  wire axss_pkg::stat_t stat,
  output axss_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL1 = 4'b0010,
    S_MUL2 = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // The result register may be reloaded once its last transfer completes.
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt   = state_r;
    cmd.load_in = 1'b0;
    cmd.mul1    = 1'b0;
    cmd.mul2    = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        // A zero target decays at a rate that needs only the first product.
        state_nxt = stat.tgt_zero ? S_UPD : S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

### src/axss_dp.sv
// ============================================================================
// axss_dp
// Datapath: target clamp and deadzone, shared multiplier, step saturation,
// held value update and the result register.
// ============================================================================
`default_nettype none

module axss_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire axss_pkg::cfg_t      cfg,
  input  wire axss_pkg::cmd_t      cmd,
  output axss_pkg::stat_t          stat,
  input  wire logic signed [16:0]  raw_sum,
  input  wire logic        [15:0]  frame_time,
  output logic signed      [15:0]  smoothed_value,
  output logic signed      [15:0]  target_level
);

  logic signed [15:0] tgt_r, tgt_nxt;
  logic signed [15:0] held_r, held_nxt;
  logic        [15:0] ft_r;
  logic        [31:0] prod1_r;
  logic        [46:0] prod2_r;
  logic signed [15:0] out_val_r;
  logic signed [15:0] out_tgt_r;

  logic signed [16:0] clamp_c;
  logic signed [16:0] clamp_neg;
  logic        [14:0] clamp_mag;
  logic signed [15:0] tgt_neg;
  logic        [14:0] tgt_mag;

  logic        [31:0] mul_a;
  logic        [15:0] mul_b;
  logic        [47:0] mul_res;

  logic        [14:0] step_c;
  logic signed [16:0] held_x, tgt_x, step_x, gap_x, gap_abs, held_abs, upd_x;
  logic               snap_hit;

  // Clamp to +-1.0, then apply the deadzone.
  always_comb begin
    if (raw_sum > axss_pkg::RAW_POS_MAX) begin
      clamp_c = axss_pkg::RAW_POS_MAX;
    end else if (raw_sum < axss_pkg::RAW_NEG_MAX) begin
      clamp_c = axss_pkg::RAW_NEG_MAX;
    end else begin
      clamp_c = raw_sum;
    end
    clamp_neg = -clamp_c;
    clamp_mag = clamp_c[16] ? clamp_neg[14:0] : clamp_c[14:0];
    if (clamp_mag < cfg.deadzone_level) begin
      tgt_nxt = 16'sd0;
    end else begin
      tgt_nxt = clamp_c[15:0];
    end
  end

  assign stat.tgt_zero = (tgt_r == 16'sd0);
  assign tgt_neg       = -tgt_r;
  assign tgt_mag       = tgt_r[15] ? tgt_neg[14:0] : tgt_r[14:0];

  // One multiplier serves both passes.
  always_comb begin
    if (cmd.mul2) begin
      mul_a = prod1_r;
      mul_b = {1'b0, tgt_mag};
    end else begin
      mul_a = {16'd0, ft_r};
      mul_b = stat.tgt_zero ? cfg.fall_rate : cfg.rise_rate;
    end
  end
  assign mul_res = mul_a * mul_b;

  assign snap_hit = cfg.snap_enable &&
                    ((held_r > 16'sd0 && tgt_r < 16'sd0) ||
                     (held_r < 16'sd0 && tgt_r > 16'sd0));

  // Step size, truncated and saturated.
  always_comb begin
    if (stat.tgt_zero) begin
      step_c = (|prod1_r[31:25]) ? axss_pkg::STEP_MAX : prod1_r[24:10];
    end else begin
      step_c = (|prod2_r[46:39]) ? axss_pkg::STEP_MAX : prod2_r[38:24];
    end
  end

  always_comb begin
    held_x   = {held_r[15], held_r};
    tgt_x    = {tgt_r[15], tgt_r};
    step_x   = {2'b00, step_c};
    gap_x    = tgt_x - held_x;
    gap_abs  = gap_x[16] ? -gap_x : gap_x;
    held_abs = held_x[16] ? -held_x : held_x;
    if (!stat.tgt_zero) begin
      if (gap_abs < step_x) begin
        upd_x = tgt_x;
      end else if (tgt_x > held_x) begin
        upd_x = held_x + step_x;
      end else if (tgt_x < held_x) begin
        upd_x = held_x - step_x;
      end else begin
        upd_x = held_x;
      end
    end else begin
      // Decay toward zero; a value already at zero stays there.
      if (held_abs < step_x) begin
        upd_x = 17'sd0;
      end else if (held_x > 17'sd0) begin
        upd_x = held_x - step_x;
      end else begin
        upd_x = held_x + step_x;
      end
    end
  end

  always_comb begin
    held_nxt = held_r;
    if (cmd.mul1 && snap_hit) begin
      held_nxt = 16'sd0;
    end else if (cmd.commit) begin
      held_nxt = upd_x[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 16'sd0;
    end else begin
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tgt_r <= tgt_nxt;
      ft_r  <= frame_time;
    end
    if (cmd.mul1) begin
      prod1_r <= mul_res[31:0];
    end
    if (cmd.mul2) begin
      prod2_r <= mul_res[46:0];
    end
    if (cmd.commit) begin
      out_val_r <= upd_x[15:0];
      out_tgt_r <= tgt_r;
    end
  end

  assign smoothed_value = out_val_r;
  assign target_level   = out_tgt_r;

endmodule

`default_nettype wire

### src/axis_slew_smoother_core.sv
// ============================================================================
// axis_slew_smoother_core
// Per-frame slew-rate limiter with deadzone and optional snap on reversal.
// ============================================================================
// Usage: one input transfer per frame on in_* carries the summed raw axis
// value and the frame time; one output transfer on out_* returns the held
// value after that frame and the target after clamp and deadzone.
// Registers are written through cfg_* at byte addresses 0, 4, 8 and 12
// (deadzone, snap enable, rise rate, fall rate); the user must write them
// only while no frame is in flight: the block does not enforce this.
// pready is always high and reads return the register contents.
// Sequence: the input transfer captures the frame, then come the first
// multiplier pass, the second pass for a nonzero target only, and the
// update step, which loads the result register. One frame is worked on at
// a time, with the single shared multiplier used twice for a nonzero target.
// The result waits in an output register while the next frame is taken; if
// the receiver still stalls at the next update step, the block holds there
// until the register frees up. Reset (rst_n low, synchronous) clears the
// held value to zero, drops out_tvalid and restores the register defaults.
// ============================================================================
`default_nettype none

module axis_slew_smoother_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,    // [16:0] raw_sum, [32:17] frame_time
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,   // [15:0] smoothed_value, [31:16] target_level
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  axss_pkg::cfg_t     cfg;
  axss_pkg::cmd_t     cmd;
  axss_pkg::stat_t    stat;
  logic signed [15:0] smoothed_value;
  logic signed [15:0] target_level;

  assign cfg_pready = 1'b1;

  axss_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  axss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  axss_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (cmd),
    .stat           (stat),
    .raw_sum        ($signed(in_tdata[16:0])),
    .frame_time     (in_tdata[32:17]),
    .smoothed_value (smoothed_value),
    .target_level   (target_level)
  );

  assign out_tdata = {target_level, smoothed_value};

`ifndef SYNTHESIS
  // Only one frame is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a frame is still in flight");

  // A new result is loaded exactly when the sequencer returns to idle.
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result became valid outside the return to idle");

  // The held value and target never leave +-1.0.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (smoothed_value <= 16'sd16384) && (smoothed_value >= -16'sd16384) &&
                   (target_level <= 16'sd16384) && (target_level >= -16'sd16384))
    else $error("result outside the unit range");
`endif

endmodule

`default_nettype wire
